// ===== rtl/core/mwi_pkg.sv =====
// ----------------------------------------------------------------------------
// mwi_pkg
// Shared types and constants of the morphing wavetable interpolator: item
// layouts, register indexes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package mwi_pkg;

  localparam int VALUE_W     = 15;
  localparam int POS_W       = 27;
  localparam int MORPH_W     = 12;
  localparam int FRAC_W      = 16;
  localparam int SAMPLE_OUT_W = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 27;
  localparam int CNT_W       = 3;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_SPAN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_SHIFT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAC_SHIFT  = 2'd2;

  localparam logic [26:0] SPAN_RESET        = 27'd16777216;
  localparam logic [3:0]  INDEX_SHIFT_RESET = 4'd9;
  localparam logic [4:0]  FRAC_SHIFT_RESET  = 5'd7;

  typedef struct packed {
    logic        cmd;
    logic        table_select;
    logic [4:0]  wave_index;
    logic [10:0] sample_index;
    logic [14:0] table_value;
    logic [26:0] position;
    logic [11:0] morph;
  } in_item_t;

  typedef struct packed {
    logic [11:0] sample;
    logic        rising;
    logic        release_phase;
    logic        phase_changed;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_FETCH = 5'b00100,
    S_BLEND = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

// ===== rtl/core/morphing_wavetable_interpolator.sv =====
// ----------------------------------------------------------------------------
// morphing_wavetable_interpolator
// Bilinear wavetable interpolator with attack and release wave families.
// ----------------------------------------------------------------------------
// A write item stores one 15-bit sample and yields no result; the block stays
// ready for the next item. A render item runs through position reflection and
// morph split, the four neighbour reads through the single read port of the
// sample store, and the three blends through one shared multiplier, then loads
// its result into the output register, where it waits if the consumer stalls.
// No new item is taken until that result has been loaded. The store holds
// nothing useful until written, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module morphing_wavetable_interpolator #(
  parameter int WAVE_SAMPLES = 256,
  parameter int FAMILY_WAVES = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mwi_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mwi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mwi_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mwi_pkg::out_item_t                  out_data
);

  localparam int SAMPLE_W = $clog2(WAVE_SAMPLES + 1);
  localparam int WAVE_W   = $clog2(FAMILY_WAVES);
  localparam int ROW_W    = $clog2(2 * FAMILY_WAVES);
  localparam int ADDR_W   = ROW_W + SAMPLE_W;
  localparam int DEPTH    = (2 * FAMILY_WAVES) << SAMPLE_W;

  localparam logic [11:0]       S_LIMIT    = 12'(WAVE_SAMPLES);
  localparam logic [12:0]       F_LIMIT    = 13'(FAMILY_WAVES - 1);
  localparam logic [ROW_W-1:0]  ROW_OFFSET = ROW_W'(FAMILY_WAVES);
  localparam logic [4:0]        WAVE_COUNT = 5'(FAMILY_WAVES);
  localparam logic [10:0]       SAMPLE_TOP = 11'(WAVE_SAMPLES);

  mwi_pkg::state_t state;

  logic [26:0] span_length;
  logic [3:0]  morph_index_shift;
  logic [4:0]  morph_frac_shift;

  logic [mwi_pkg::CNT_W-1:0] cnt;

  logic [26:0] pos_q;
  logic [11:0] morph_q;
  logic        phase_q;
  logic [26:0] p_q;
  logic [11:0] f_raw_q;
  logic [15:0] mfrac_q;

  logic [mwi_pkg::VALUE_W-1:0] taps [4];
  logic [mwi_pkg::VALUE_W-1:0] left;
  logic [mwi_pkg::VALUE_W-1:0] right;

  logic slope_flag;
  logic last_phase;

  // prep logic
  logic        phase_c;
  logic [27:0] twice;
  logic [27:0] refl;
  logic [26:0] p_c;
  logic [11:0] rem;
  logic [15:0] rem16;

  // fetch addressing
  logic [11:0]         s_raw;
  logic [11:0]         s_inc;
  logic [11:0]         s0c;
  logic [11:0]         s1c;
  logic [12:0]         f_ext;
  logic [12:0]         f_inc;
  logic [12:0]         f0c;
  logic [12:0]         f1c;
  logic [WAVE_W-1:0]   f_sel;
  logic [SAMPLE_W-1:0] s_sel;
  logic [ROW_W-1:0]    rd_row;

  // table ports
  logic                        wr_en;
  logic [ROW_W-1:0]            wr_row;
  logic [ADDR_W-1:0]           wr_addr;
  logic                        rd_en;
  logic [ADDR_W-1:0]           rd_addr;
  logic [mwi_pkg::VALUE_W-1:0] rd_data;

  // blend unit
  logic                        lerp_en;
  logic [mwi_pkg::VALUE_W-1:0] lerp_a;
  logic [mwi_pkg::VALUE_W-1:0] lerp_b;
  logic [mwi_pkg::FRAC_W-1:0]  lerp_frac;
  logic [mwi_pkg::VALUE_W-1:0] lerp_y;

  logic in_fire;
  logic out_load;
  logic rising_next;

  assign in_ready = (state == mwi_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == mwi_pkg::S_DONE) && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      span_length       <= mwi_pkg::SPAN_RESET;
      morph_index_shift <= mwi_pkg::INDEX_SHIFT_RESET;
      morph_frac_shift  <= mwi_pkg::FRAC_SHIFT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mwi_pkg::REG_SPAN_LENGTH: span_length       <= cfg_data;
        mwi_pkg::REG_INDEX_SHIFT: morph_index_shift <= cfg_data[3:0];
        mwi_pkg::REG_FRAC_SHIFT:  morph_frac_shift  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // table writes
  always_comb begin
    wr_row  = in_data.table_select ? ROW_W'(in_data.wave_index) + ROW_OFFSET
                                   : ROW_W'(in_data.wave_index);
    wr_addr = {wr_row, in_data.sample_index[SAMPLE_W-1:0]};
    wr_en   = in_fire && (in_data.cmd == mwi_pkg::CMD_WRITE) &&
              (in_data.wave_index < WAVE_COUNT) && (in_data.sample_index <= SAMPLE_TOP);
  end

  // reflection and morph split
  always_comb begin
    phase_c = (pos_q >= span_length);
    twice   = {span_length, 1'b0};
    refl    = (twice > {1'b0, pos_q}) ? twice - {1'b0, pos_q} : 28'd0;
    p_c     = phase_c ? refl[26:0] : pos_q;
    rem     = morph_q & ~(12'hFFF << morph_index_shift);
    rem16   = 16'(rem);
  end

  // neighbour addressing, order l1 l2 r1 r2
  always_comb begin
    s_raw = {1'b0, p_q[26:16]};
    s_inc = s_raw + 12'd1;
    s0c   = (s_raw > S_LIMIT) ? S_LIMIT : s_raw;
    s1c   = (s_inc > S_LIMIT) ? S_LIMIT : s_inc;
    f_ext = {1'b0, f_raw_q};
    f_inc = f_ext + 13'd1;
    f0c   = (f_ext > F_LIMIT) ? F_LIMIT : f_ext;
    f1c   = (f_inc > F_LIMIT) ? F_LIMIT : f_inc;
    f_sel = cnt[0] ? f1c[WAVE_W-1:0] : f0c[WAVE_W-1:0];
    s_sel = cnt[1] ? s1c[SAMPLE_W-1:0] : s0c[SAMPLE_W-1:0];
    rd_row  = phase_q ? ROW_W'(f_sel) + ROW_OFFSET : ROW_W'(f_sel);
    rd_addr = {rd_row, s_sel};
    rd_en   = (state == mwi_pkg::S_FETCH) && (cnt < 3'd4);
  end

  // blend operand selection
  always_comb begin
    lerp_en   = (state == mwi_pkg::S_BLEND) && (cnt < 3'd3);
    lerp_a    = taps[3];
    lerp_b    = taps[2];
    lerp_frac = mfrac_q;
    case (cnt)
      3'd1: begin
        lerp_a = taps[1];
        lerp_b = taps[0];
      end
      3'd2: begin
        lerp_a    = left;
        lerp_b    = lerp_y;
        lerp_frac = p_q[15:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    if (left < right) begin
      rising_next = 1'b1;
    end else if (right < left) begin
      rising_next = 1'b0;
    end else begin
      rising_next = slope_flag;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mwi_pkg::S_IDLE;
      cnt        <= '0;
      out_valid  <= 1'b0;
      slope_flag <= 1'b0;
      last_phase <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mwi_pkg::S_IDLE: begin
          if (in_fire && (in_data.cmd == mwi_pkg::CMD_RENDER)) begin
            state <= mwi_pkg::S_PREP;
          end
        end
        mwi_pkg::S_PREP: begin
          cnt   <= '0;
          state <= mwi_pkg::S_FETCH;
        end
        mwi_pkg::S_FETCH: begin
          if (cnt == 3'd4) begin
            cnt   <= '0;
            state <= mwi_pkg::S_BLEND;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        mwi_pkg::S_BLEND: begin
          if (cnt == 3'd3) begin
            state <= mwi_pkg::S_DONE;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        mwi_pkg::S_DONE: begin
          if (out_load) begin
            out_valid  <= 1'b1;
            slope_flag <= rising_next;
            last_phase <= phase_q;
            state      <= mwi_pkg::S_IDLE;
          end
        end
        default: state <= mwi_pkg::S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_q   <= in_data.position;
      morph_q <= in_data.morph;
    end
    if (state == mwi_pkg::S_PREP) begin
      phase_q <= phase_c;
      p_q     <= p_c;
      f_raw_q <= morph_q >> morph_index_shift;
      mfrac_q <= rem16 << morph_frac_shift;
    end
    if ((state == mwi_pkg::S_FETCH) && (cnt != 3'd0)) begin
      taps[3] <= taps[2];
      taps[2] <= taps[1];
      taps[1] <= taps[0];
      taps[0] <= rd_data;
    end
    if ((state == mwi_pkg::S_BLEND) && (cnt == 3'd1)) begin
      left <= lerp_y;
    end
    if ((state == mwi_pkg::S_BLEND) && (cnt == 3'd2)) begin
      right <= lerp_y;
    end
    if (out_load) begin
      out_data.sample        <= lerp_y[mwi_pkg::VALUE_W-1:3];
      out_data.rising        <= rising_next;
      out_data.release_phase <= phase_q;
      out_data.phase_changed <= phase_q ^ last_phase;
    end
  end

  mwi_table #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.table_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mwi_lerp u_lerp (
    .clk  (clk),
    .en   (lerp_en),
    .a    (lerp_a),
    .b    (lerp_b),
    .frac (lerp_frac),
    .y    (lerp_y)
  );

`ifndef NO_ASSERTIONS
  a_render_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_data.cmd == mwi_pkg::CMD_RENDER) |=> !in_ready)
    else $error("render item accepted but block still ready");

  a_fetch_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mwi_pkg::S_FETCH) |-> (cnt <= 3'd4))
    else $error("fetch counter out of range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == mwi_pkg::S_DONE))
    else $error("result raised outside the final step");
`endif

endmodule

// ===== rtl/core/mwi_table.sv =====
// ----------------------------------------------------------------------------
// mwi_table
// Wave sample store for both families: one write port, one registered read
// port.
// ----------------------------------------------------------------------------
module mwi_table #(
  parameter int ADDR_W = 14,
  parameter int DEPTH  = 9216
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [mwi_pkg::VALUE_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [mwi_pkg::VALUE_W-1:0]  rd_data
);

  logic [mwi_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/mwi_lerp.sv =====
// ----------------------------------------------------------------------------
// mwi_lerp
// Shared fixed-point blend unit: y = a + ((b - a) * frac) >> 16, registered.
// ----------------------------------------------------------------------------
module mwi_lerp (
  input  logic                         clk,
  input  logic                         en,
  input  logic [mwi_pkg::VALUE_W-1:0]  a,
  input  logic [mwi_pkg::VALUE_W-1:0]  b,
  input  logic [mwi_pkg::FRAC_W-1:0]   frac,
  output logic [mwi_pkg::VALUE_W-1:0]  y
);

  logic signed [15:0] diff;
  logic signed [32:0] prod;
  logic signed [17:0] sum;

  always_comb begin
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, frac});
    sum  = $signed({3'b000, a}) + 18'(prod[32:16]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= sum[mwi_pkg::VALUE_W-1:0];
    end
  end

endmodule

// ===== bench/morphing_wavetable_interpolator_tb.sv =====
// ----------------------------------------------------------------------------
// morphing_wavetable_interpolator_tb
// Self-checking bench for the morphing wavetable interpolator. Both wave
// families are loaded in full, then directed renders, register masking, the
// register extremes and random mixes of renders and table writes run under
// bursty input traffic and a stalling consumer. An in-bench interpolator
// predicts every render and each item out is compared field by field.
// ----------------------------------------------------------------------------
module morphing_wavetable_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WAVE_SAMPLES  = 256;
  localparam int FAMILY_WAVES  = 9;
  localparam int WAVE_STRIDE   = WAVE_SAMPLES + 1;
  localparam int TABLE_DEPTH   = FAMILY_WAVES * WAVE_STRIDE;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [27:0] POS_MAX = 28'h7FFFFFF;
  localparam logic [14:0] FLAT_LEVEL = 15'h2AAA;
  localparam logic [mwi_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [mwi_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mwi_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  mwi_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mwi_pkg::out_item_t out_data;

  // interpolator state mirrored in the bench
  logic [14:0] attack_mem [0:TABLE_DEPTH-1];
  logic [14:0] release_mem [0:TABLE_DEPTH-1];
  logic slope_state = 1'b0;
  logic prev_phase = 1'b0;
  logic [26:0] span_reg = mwi_pkg::SPAN_RESET;
  logic [3:0] index_shift_reg = mwi_pkg::INDEX_SHIFT_RESET;
  logic [4:0] frac_shift_reg = mwi_pkg::FRAC_SHIFT_RESET;

  mwi_pkg::out_item_t expected_samples[$];
  mwi_pkg::out_item_t result_want;
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int render_count = 0;
  int release_count = 0;
  int hold_count = 0;
  int write_count = 0;
  int ignored_writes = 0;
  int setting_count = 0;
  logic [31:0] ready_step = '0;
  logic [15:0] ready_pattern = 16'hFFFF;

  morphing_wavetable_interpolator u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // consumer stall pattern, a 16-bit ready mask that is reshuffled at random
  always @(posedge clk) begin
    ready_step <= ready_step + 1;
    if (ready_step[5:0] == 6'd63) begin
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end
    out_ready <= ready_pattern[ready_step[3:0]];
  end

  function automatic logic [31:0] lerp16(input logic [31:0] a, input logic [31:0] b,
                                         input logic [15:0] frac);
    logic [63:0] acc;
    acc = 64'(a) * (64'd65536 - 64'(frac)) + 64'(b) * 64'(frac);
    return acc[47:16];
  endfunction

  function automatic logic [31:0] table_read(input logic rel, input int unsigned f,
                                             input int unsigned s);
    return rel ? 32'(release_mem[f * WAVE_STRIDE + s]) : 32'(attack_mem[f * WAVE_STRIDE + s]);
  endfunction

  task automatic interpolate_item(input mwi_pkg::in_item_t it);
    int unsigned s_raw, f_raw, s0, s1, f0, f1, rem;
    logic [27:0] twice_span;
    logic [26:0] p;
    logic [15:0] wave_frac, mix_frac;
    logic [31:0] left_mix, right_mix;
    logic phase;
    mwi_pkg::out_item_t res;
    if (it.cmd == mwi_pkg::CMD_WRITE) begin
      write_count++;
      if (it.wave_index < FAMILY_WAVES && it.sample_index <= WAVE_SAMPLES) begin
        if (it.table_select) release_mem[it.wave_index * WAVE_STRIDE + it.sample_index] = it.table_value;
        else attack_mem[it.wave_index * WAVE_STRIDE + it.sample_index] = it.table_value;
      end else begin
        ignored_writes++;
      end
    end else begin
      render_count++;
      phase = (it.position >= span_reg);
      p = it.position;
      if (phase) begin
        release_count++;
        twice_span = {span_reg, 1'b0};
        p = (twice_span > {1'b0, it.position}) ? 27'(twice_span - {1'b0, it.position}) : '0;
      end
      s_raw = p[26:16];
      wave_frac = p[15:0];
      f_raw = it.morph >> index_shift_reg;
      rem = it.morph - (f_raw << index_shift_reg);
      mix_frac = 16'(rem << frac_shift_reg);
      s0 = (s_raw > WAVE_SAMPLES) ? WAVE_SAMPLES : s_raw;
      s1 = (s_raw + 1 > WAVE_SAMPLES) ? WAVE_SAMPLES : s_raw + 1;
      f0 = (f_raw > FAMILY_WAVES - 1) ? FAMILY_WAVES - 1 : f_raw;
      f1 = (f_raw + 1 > FAMILY_WAVES - 1) ? FAMILY_WAVES - 1 : f_raw + 1;
      left_mix = lerp16(table_read(phase, f0, s0), table_read(phase, f1, s0), mix_frac);
      right_mix = lerp16(table_read(phase, f0, s1), table_read(phase, f1, s1), mix_frac);
      if (left_mix < right_mix) slope_state = 1'b1;
      else if (right_mix < left_mix) slope_state = 1'b0;
      else hold_count++;
      res.sample = 12'(lerp16(left_mix, right_mix, wave_frac) >> 3);
      res.rising = slope_state;
      res.release_phase = phase;
      res.phase_changed = (phase != prev_phase);
      prev_phase = phase;
      expected_samples.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected item out, expected none, actual %p", $time, out_data);
        error_count++;
      end else begin
        result_want = expected_samples.pop_front();
        check_field("sample", result_want.sample, out_data.sample);
        check_field("rising", result_want.rising, out_data.rising);
        check_field("release_phase", result_want.release_phase, out_data.release_phase);
        check_field("phase_changed", result_want.phase_changed, out_data.phase_changed);
      end
    end
  end

  // bursts of random length with random gaps in between
  task automatic send_item(input mwi_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    interpolate_item(it);
  endtask

  function automatic mwi_pkg::in_item_t random_payload();
    mwi_pkg::in_item_t it;
    it.cmd = mwi_pkg::CMD_WRITE;
    it.table_select = 1'($urandom);
    it.wave_index = 5'($urandom);
    it.sample_index = 11'($urandom);
    it.table_value = 15'($urandom);
    it.position = 27'($urandom);
    it.morph = 12'($urandom);
    return it;
  endfunction

  task automatic send_write(input logic sel, input int unsigned w, input int unsigned s,
                            input logic [14:0] v);
    mwi_pkg::in_item_t it;
    it = random_payload();
    it.cmd = mwi_pkg::CMD_WRITE;
    it.table_select = sel;
    it.wave_index = 5'(w);
    it.sample_index = 11'(s);
    it.table_value = v;
    send_item(it);
  endtask

  task automatic send_render(input logic [26:0] pos, input logic [11:0] morph);
    mwi_pkg::in_item_t it;
    it = random_payload();
    it.cmd = mwi_pkg::CMD_RENDER;
    it.position = pos;
    it.morph = morph;
    send_item(it);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mwi_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mwi_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      mwi_pkg::REG_SPAN_LENGTH: span_reg = data[26:0];
      mwi_pkg::REG_INDEX_SHIFT: index_shift_reg = data[3:0];
      mwi_pkg::REG_FRAC_SHIFT:  frac_shift_reg = data[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_settings(input int unsigned span, input int unsigned ishift,
                                input int unsigned fshift);
    wait_for_results();
    write_reg(mwi_pkg::REG_SPAN_LENGTH, mwi_pkg::CFG_DATA_W'(span));
    write_reg(mwi_pkg::REG_INDEX_SHIFT, mwi_pkg::CFG_DATA_W'(ishift));
    write_reg(mwi_pkg::REG_FRAC_SHIFT, mwi_pkg::CFG_DATA_W'(fshift));
    setting_count++;
  endtask

  function automatic logic [26:0] pick_position();
    logic [27:0] twice_span, top;
    twice_span = {span_reg, 1'b0};
    top = (twice_span - 28'd1 > POS_MAX) ? POS_MAX : twice_span - 28'd1;
    case ($urandom_range(0, 9)) inside
      0: return span_reg - 27'd1;
      1: return span_reg;
      2: return 27'(top);
      3: return 27'($urandom);
      4, 5, 6: return 27'($urandom_range(0, span_reg - 1));
      7, 8: return 27'($urandom_range(span_reg, top));
      default: return {11'($urandom), ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
    endcase
  endfunction

  function automatic logic [11:0] pick_morph();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic run_mix(input int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 7) begin
        send_render(pick_position(), pick_morph());
      end else if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1))
          send_write(1'($urandom), $urandom_range(9, 31), $urandom_range(0, 2047), 15'($urandom));
        else
          send_write(1'($urandom), $urandom_range(0, 31), $urandom_range(257, 2047),
                     15'($urandom));
      end else begin
        send_write(1'($urandom), $urandom_range(0, FAMILY_WAVES - 1),
                   $urandom_range(0, WAVE_SAMPLES), 15'($urandom));
      end
    end
  endtask

  // every entry of both families, with a flat stretch at the start of each wave
  task automatic load_tables();
    for (int fam = 0; fam < 2; fam++) begin
      for (int w = 0; w < FAMILY_WAVES; w++) begin
        for (int s = 0; s <= WAVE_SAMPLES; s++) begin
          send_write(1'(fam), w, s, (s <= 7) ? FLAT_LEVEL : 15'($urandom));
        end
      end
    end
  endtask

  task automatic test_directed();
    logic [26:0] twice_span;
    twice_span = 27'({span_reg, 1'b0});
    send_write(1'b0, 8, 100, 15'd0);
    send_write(1'b0, 8, 101, 15'h7FFF);
    send_write(1'b1, 8, 100, 15'h7FFF);
    send_write(1'b1, 8, 101, 15'd0);
    // out of range, must leave the tables alone
    send_write(1'b0, 9, 0, 15'd0);
    send_write(1'b1, 31, 2047, 15'd0);
    send_write(1'b0, 0, 257, 15'h7FFF);
    send_render(27'd0, 12'd0);
    send_render(27'(100 << 16), 12'hFFF);
    send_render(27'((100 << 16) + 16'h8000), 12'hFFF);
    send_render(span_reg - 27'd1, 12'd0);
    send_render(span_reg, 12'd0);
    send_render(twice_span - 27'(100 << 16), 12'hFFF);
    send_render(twice_span - 27'(3 << 16), 12'd0);
    send_render(twice_span - 27'd1, 12'd2048);
    send_render(twice_span, 12'd0);
    send_render(27'h7FFFFFF, 12'hFFF);
    send_render(27'd12345, 12'd511);
    send_render(27'h000FFFF, 12'd512);
    send_render(27'd5, 12'hFFF);
  endtask

  // upper bits beyond each register and the spare index must do nothing
  task automatic test_register_masking();
    wait_for_results();
    write_reg(mwi_pkg::REG_INDEX_SHIFT, 27'h7FFFFF4);
    write_reg(mwi_pkg::REG_FRAC_SHIFT, 27'h7FFFFEC);
    write_reg(REG_SPARE, 27'h5A5A5A5);
    write_reg(mwi_pkg::REG_SPAN_LENGTH, 27'h0100000);
    setting_count++;
    run_mix(20);
  endtask

  task automatic test_config_extremes();
    apply_settings(65536, 0, 0);
    run_mix(60);
    apply_settings(65536, 12, 16);
    run_mix(60);
    apply_settings(67108864, 0, 16);
    run_mix(60);
    apply_settings(67108864, 12, 0);
    run_mix(60);
    apply_settings(1 << 20, 4, 12);
    run_mix(60);
    apply_settings(16777216, 9, 7);
    run_mix(60);
  endtask

  task automatic test_random_traffic();
    repeat (4) begin
      apply_settings($urandom_range(65536, 67108864), $urandom_range(0, 12),
                     $urandom_range(0, 16));
      run_mix(100);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    load_tables();
    test_directed();
    test_register_masking();
    test_config_extremes();
    test_random_traffic();
    wait_for_results();
    $display("covered %0d renders (%0d in the release half, %0d with the slope held)",
             render_count, release_count, hold_count);
    $display("and %0d table writes (%0d out of range) over %0d register settings",
             write_count, ignored_writes, setting_count);
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mwi_pkg.sv
rtl/core/mwi_table.sv
rtl/core/mwi_lerp.sv
rtl/core/morphing_wavetable_interpolator.sv
bench/morphing_wavetable_interpolator_tb.sv
